FILE: hdl/sief_pkg.sv
`default_nettype none

package sief_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] CFG_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_CTRL_ZERO = 2'd1;
    localparam logic [1:0] CFG_CTRL_ONE  = 2'd2;

    localparam logic [7:0] RST_ADDRESS   = 8'd3;
    localparam logic [7:0] RST_CTRL_ZERO = 8'd0;
    localparam logic [7:0] RST_CTRL_ONE  = 8'd64;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic       hdr;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
        logic       last;
        logic [7:0] check;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        PH_NEW,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_DATA,
        PH_DATA2,
        PH_CHK,
        PH_CHK2,
        PH_END
    } t_phase;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sief_front.sv
`default_nettype none

module sief_front
    import sief_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_frame_number,
    input  wire logic                 i_last_byte,
    output t_cmd                      o_cmd
);

    logic [7:0] r_address;
    logic [7:0] r_ctrl_zero;
    logic [7:0] r_ctrl_one;
    logic       r_inside;
    logic [7:0] r_check;
    logic [7:0] check_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address   <= RST_ADDRESS;
            r_ctrl_zero <= RST_CTRL_ZERO;
            r_ctrl_one  <= RST_CTRL_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDRESS:   r_address   <= i_cfg_data;
                CFG_CTRL_ZERO: r_ctrl_zero <= i_cfg_data;
                CFG_CTRL_ONE:  r_ctrl_one  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Start a fresh check at a frame's first byte.
    assign check_sum = (r_inside ? r_check : 8'd0) ^ i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_check  <= 8'd0;
        end else if (i_accept) begin
            r_inside <= !i_last_byte;
            r_check  <= i_last_byte ? 8'd0 : check_sum;
        end
    end

    always_comb begin
        o_cmd.hdr   = !r_inside;
        o_cmd.addr  = r_address;
        o_cmd.ctrl  = i_frame_number ? r_ctrl_one : r_ctrl_zero;
        o_cmd.data  = i_data_byte;
        o_cmd.last  = i_last_byte;
        o_cmd.check = check_sum;
    end

endmodule

`default_nettype wire

FILE: hdl/sief_queue.sv
`default_nettype none

module sief_queue
    import sief_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_cmd,
    input  wire logic i_rd,
    output t_cmd      o_cmd,
    output t_q_stat   o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    t_cmd             r_head;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign do_wr = i_wr && (r_cnt != FULL_CNT);
    assign do_rd = i_rd && (r_cnt != '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Load the next head; take the incoming item when it lands in the head slot.
    always_ff @(posedge i_clk) begin
        if (do_wr && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_cmd;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            r_rd_ptr <= n_rd_ptr;
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_cmd  = r_head;
    assign o_stat = '{full: (r_cnt == FULL_CNT), empty: (r_cnt == '0)};

endmodule

`default_nettype wire

FILE: hdl/sief_back.sv
`default_nettype none

module sief_back
    import sief_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cmd_empty,
    output logic            o_cmd_done,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_end,
    output logic            o_last_of_run
);

    t_phase     r_phase;
    t_phase     n_phase;
    t_phase     cur;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_last;
    logic       advance;
    logic       emit;
    logic [7:0] byte_v;
    logic       end_v;
    logic       done_v;
    t_phase     after;

    assign advance = !r_valid || i_pop;
    assign emit    = advance && !i_cmd_empty;

    always_comb begin
        cur = r_phase;
        if (r_phase == PH_NEW) begin
            cur = i_cmd.hdr ? PH_FLAG : PH_DATA;
        end
    end

    always_comb begin
        byte_v = FLAG_BYTE;
        end_v  = 1'b0;
        done_v = 1'b0;
        after  = PH_NEW;
        unique case (cur)
            PH_FLAG: begin
                byte_v = FLAG_BYTE;
                after  = PH_ADDR;
            end
            PH_ADDR: begin
                byte_v = i_cmd.addr;
                after  = PH_CTRL;
            end
            PH_CTRL: begin
                byte_v = i_cmd.ctrl;
                after  = PH_HCHK;
            end
            PH_HCHK: begin
                byte_v = i_cmd.addr ^ i_cmd.ctrl;
                after  = PH_DATA;
            end
            PH_DATA: begin
                if (needs_esc(i_cmd.data)) begin
                    byte_v = ESC_BYTE;
                    after  = PH_DATA2;
                end else begin
                    byte_v = i_cmd.data;
                    after  = i_cmd.last ? PH_CHK : PH_NEW;
                    done_v = !i_cmd.last;
                end
            end
            PH_DATA2: begin
                byte_v = i_cmd.data ^ ESC_XOR;
                after  = i_cmd.last ? PH_CHK : PH_NEW;
                done_v = !i_cmd.last;
            end
            PH_CHK: begin
                if (needs_esc(i_cmd.check)) begin
                    byte_v = ESC_BYTE;
                    after  = PH_CHK2;
                end else begin
                    byte_v = i_cmd.check;
                    after  = PH_END;
                end
            end
            PH_CHK2: begin
                byte_v = i_cmd.check ^ ESC_XOR;
                after  = PH_END;
            end
            PH_END: begin
                byte_v = FLAG_BYTE;
                end_v  = 1'b1;
                done_v = 1'b1;
                after  = PH_NEW;
            end
            default: begin
                after = PH_NEW;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (emit) begin
            n_phase = after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NEW;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (advance) begin
                r_valid <= !i_cmd_empty;
            end
        end
    end

    // Hold the shown byte until it is taken.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= byte_v;
            r_end  <= end_v;
            r_last <= done_v;
        end
    end

    assign o_cmd_done    = emit && done_v;
    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_frame_end   = r_end;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

FILE: hdl/stuffed_info_frame_encoder.sv
// The first byte caused by an item passes the queue head register, then the output
// register, before it is shown. The back sequencer shows one output byte per cycle
// while the receiver pops and an item waits; an item causes 1 or 2 bytes of plain
// payload, up to 9 for a single-byte frame. The front takes one item per cycle while
// the command queue has room. Reset (synchronous, active low) closes any open frame,
// empties the queue and the output register, and loads the register defaults.
`default_nettype none

module stuffed_info_frame_encoder
    import sief_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_frame_number,
    input  wire logic                 i_last_byte,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_frame_end,
    output logic                      o_last_of_run
);

    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;
    logic    accept;
    logic    cmd_done;

    assign accept = push && !q_stat.full;
    assign full   = q_stat.full;

    sief_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_frame_number (i_frame_number),
        .i_last_byte    (i_last_byte),
        .o_cmd          (front_cmd)
    );

    sief_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_cmd   (front_cmd),
        .i_rd    (cmd_done),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    sief_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_cmd_empty   (q_stat.empty),
        .o_cmd_done    (cmd_done),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

FILE: bench/stuffed_info_frame_encoder_tb.sv
`default_nettype none

module stuffed_info_frame_encoder_tb;
    import sief_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 375;
    localparam int CALM_FROM = 320;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       last_of_run;
    } enc_byte_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;
    logic                 push;
    logic                 full;
    logic [7:0]           i_data_byte;
    logic                 i_frame_number;
    logic                 i_last_byte;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_frame_end;
    logic                 o_last_of_run;

    stuffed_info_frame_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_frame_number (i_frame_number),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_last_of_run  (o_last_of_run)
    );

    // Encoder image kept by the bench
    logic [7:0] addr_reg;
    logic [7:0] ctrl_zero_reg;
    logic [7:0] ctrl_one_reg;
    logic       frame_open;
    logic [7:0] payload_xor;

    enc_byte_t  line_bytes_due[$];
    logic [7:0] frame_buf[$];
    int         errors = 0;
    int         items_sent = 0;
    logic       calm = 1'b0;
    int         pop_stall = 0;
    int         quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_line_byte(input logic [7:0] b, input logic fend);
        enc_byte_t e;
        e.out_byte    = b;
        e.frame_end   = fend;
        e.last_of_run = 1'b0;
        line_bytes_due.push_back(e);
    endfunction

    function automatic void add_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            add_line_byte(ESC_BYTE, 1'b0);
            add_line_byte(b ^ ESC_XOR, 1'b0);
        end else begin
            add_line_byte(b, 1'b0);
        end
    endfunction

    function automatic void encode_item(input logic [7:0] d, input logic fn, input logic lb);
        logic [7:0] ctrl;
        enc_byte_t  tail;
        if (!frame_open) begin
            ctrl = fn ? ctrl_one_reg : ctrl_zero_reg;
            add_line_byte(FLAG_BYTE, 1'b0);
            add_line_byte(addr_reg, 1'b0);
            add_line_byte(ctrl, 1'b0);
            add_line_byte(addr_reg ^ ctrl, 1'b0);
            frame_open  = 1'b1;
            payload_xor = 8'h00;
        end
        add_stuffed(d);
        payload_xor = payload_xor ^ d;
        if (lb) begin
            add_stuffed(payload_xor);
            add_line_byte(FLAG_BYTE, 1'b1);
            frame_open  = 1'b0;
            payload_xor = 8'h00;
        end
        // mark the final byte this item caused
        tail = line_bytes_due.pop_back();
        tail.last_of_run = 1'b1;
        line_bytes_due.push_back(tail);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [7:0] d, input logic fn, input logic lb);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= d;
        i_frame_number <= fn;
        i_last_byte    <= lb;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encode_item(d, fn, lb);
        items_sent++;
    endtask

    // Send frame_buf as one frame; later bytes carry a random frame number.
    task automatic send_frame(input logic fn);
        for (int k = 0; k < frame_buf.size(); k++)
            send_item(frame_buf[k], (k == 0) ? fn : 1'($urandom),
                      k == frame_buf.size() - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (line_bytes_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ADDRESS:   addr_reg      = val;
            CFG_CTRL_ZERO: ctrl_zero_reg = val;
            CFG_CTRL_ONE:  ctrl_one_reg  = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] a, input logic [7:0] c0, input logic [7:0] c1);
        drain();
        write_reg(CFG_ADDRESS, a);
        write_reg(CFG_CTRL_ZERO, c0);
        write_reg(CFG_CTRL_ONE, c1);
    endtask

    task automatic test_reset_defaults();
        frame_buf = '{8'h00};
        send_frame(1'b0);
        frame_buf = '{8'hFF};
        send_frame(1'b1);
    endtask

    task automatic test_stuffing();
        frame_buf = '{FLAG_BYTE, ESC_BYTE, 8'h5E, 8'h5D, ESC_XOR};
        send_frame(1'b0);
        // payload XOR lands on the escape byte
        frame_buf = '{8'h01, 8'h7C};
        send_frame(1'b1);
        // single flag byte: payload and check both stuffed
        frame_buf = '{FLAG_BYTE};
        send_frame(1'b0);
    endtask

    task automatic test_frame_number_mid_frame();
        frame_buf = '{8'h12, 8'h34, 8'h56};
        send_frame(1'b1);
    endtask

    task automatic test_register_extremes();
        // header check equals flag and escape, sent unstuffed
        set_regs(FLAG_BYTE, 8'h00, 8'h03);
        frame_buf = '{8'hA5};
        send_frame(1'b0);
        send_frame(1'b1);
        set_regs(8'hFF, 8'hFF, 8'h00);
        send_frame(1'b0);
        send_frame(1'b1);
        set_regs(8'h00, 8'h00, 8'hFF);
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    task automatic test_write_inside_frame();
        send_item(8'h3C, 1'b0, 1'b0);
        // hold the sender until the line is quiet, then retune mid-frame
        drain();
        write_reg(CFG_ADDRESS, 8'h55);
        send_item(8'hC3, 1'b1, 1'b1);
        send_item(8'h0F, 1'b1, 1'b1);
    endtask

    task automatic test_random_frames();
        int len;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= CALM_FROM)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 11) == 0) begin
                drain();
                write_reg(CFG_IDX_W'($urandom_range(0, 2)),
                          ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            frame_buf = {};
            repeat (len) frame_buf.push_back(pick_byte());
            send_frame(1'($urandom));
        end
    endtask

    // Receiver: random stall bursts, none once calm
    always @(negedge i_clk) begin
        if (calm) begin
            pop <= 1'b1;
        end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            pop_stall <= $urandom_range(0, 16);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        enc_byte_t exp_b;
        if (i_rst_n && pop && !empty) begin
            if (line_bytes_due.size() == 0) begin
                $error("unexpected byte out_byte=%02h frame_end=%0b last_of_run=%0b",
                       o_out_byte, o_frame_end, o_last_of_run);
                errors++;
            end else begin
                exp_b = line_bytes_due.pop_front();
                if (o_out_byte !== exp_b.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", exp_b.out_byte, o_out_byte);
                    errors++;
                end
                if (o_frame_end !== exp_b.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", exp_b.frame_end, o_frame_end);
                    errors++;
                end
                if (o_last_of_run !== exp_b.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           exp_b.last_of_run, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_ADDRESS;
        i_cfg_data     = 8'h00;
        push           = 1'b0;
        i_data_byte    = 8'h00;
        i_frame_number = 1'b0;
        i_last_byte    = 1'b0;
        addr_reg       = RST_ADDRESS;
        ctrl_zero_reg  = RST_CTRL_ZERO;
        ctrl_one_reg   = RST_CTRL_ONE;
        frame_open     = 1'b0;
        payload_xor    = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_stuffing();
        test_frame_number_mid_frame();
        test_register_extremes();
        test_write_inside_frame();
        test_random_frames();

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
